>>> rtl/core/slru_pkg.sv
// Package for the segmented LRU cache: sizes, operation codes and the row types.
// Used by the channel interfaces, the row unit, the top level and the checker.
package slru_pkg;

   localparam int SEGMENTS = 16;
   localparam int WAYS = 8;
   localparam int SEG_BITS = $clog2(SEGMENTS);
   localparam int WAY_BITS = $clog2(WAYS);
   localparam int SLOT_BITS = SEG_BITS + WAY_BITS;
   localparam int FILL_BITS = $clog2(WAYS + 1);
   localparam int TOTAL_BITS = $clog2(SEGMENTS * WAYS + 1);
   localparam int CAP_BITS = 4;
   localparam int COUNT_BITS = 8;
   localparam int KEY_BITS = 32;
   localparam int DATA_BITS = 32;

   localparam logic [CAP_BITS-1:0] CAP_RESET = 4'd8;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_GET = 1'b1;

   localparam logic [1:0] ROW_HOLD = 2'd0;
   localparam logic [1:0] ROW_DROP = 2'd1;
   localparam logic [1:0] ROW_AGE = 2'd2;
   localparam logic [1:0] ROW_PROMOTE = 2'd3;

   typedef logic [WAYS-1:0] valid_row_type;
   typedef logic [WAYS-1:0][WAY_BITS-1:0] rank_row_type;

   typedef struct packed {
      logic [1:0]          op;
      logic [WAY_BITS-1:0] way;
   } row_cmd_type;

   typedef struct packed {
      logic [FILL_BITS-1:0] fill;
      logic [WAY_BITS-1:0]  oldest_way;
      logic                 free_found;
      logic [WAY_BITS-1:0]  free_way;
   } row_stat_type;

endpackage

>>> rtl/core/slru_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on slru_pkg for the field widths.
interface slru_req_if import slru_pkg::*;;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic signed [KEY_BITS-1:0]  key;
   logic signed [DATA_BITS-1:0] value;

   modport source (output valid, output kind, output key, output value, input ready);
   modport sink (input valid, input kind, input key, input value, output ready);
endinterface

interface slru_rsp_if import slru_pkg::*;;
   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic signed [DATA_BITS-1:0] read_value;
   logic [COUNT_BITS-1:0]       entry_count;

   modport source (output valid, output hit, output read_value, output entry_count,
                   input ready);
   modport sink (input valid, input hit, input read_value, input entry_count,
                 output ready);
endinterface

>>> rtl/core/slru_row_unit.sv
// Recency row unit: applies one drop, age or promote step to the ways of a segment.
// Also reports the fill, the least recent way and the first free way. Uses slru_pkg.
module slru_row_unit import slru_pkg::*; (
   input  row_cmd_type   cmd,
   input  valid_row_type valid_in,
   input  rank_row_type  rank_in,
   output valid_row_type valid_out,
   output rank_row_type  rank_out,
   output row_stat_type  stat
);

   logic [FILL_BITS-1:0] fill;
   logic [WAY_BITS-1:0]  sel_rank;

   always_comb begin
      fill = '0;
      for (int w = 0; w < WAYS; w++) begin
         fill = fill + FILL_BITS'(valid_in[w]);
      end
   end

   always_comb begin
      stat.fill = fill;
      stat.oldest_way = '0;
      stat.free_found = 1'b0;
      stat.free_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (valid_in[w] && (FILL_BITS'(rank_in[w]) + FILL_BITS'(1)) == fill) begin
            stat.oldest_way = WAY_BITS'(w);
         end
         if (!valid_in[w]) begin
            stat.free_found = 1'b1;
            stat.free_way = WAY_BITS'(w);
         end
      end
   end

   assign sel_rank = rank_in[cmd.way];

   always_comb begin
      valid_out = valid_in;
      rank_out = rank_in;
      case (cmd.op)
         ROW_DROP: begin
            for (int w = 0; w < WAYS; w++) begin
               if (valid_in[w] && rank_in[w] > sel_rank) begin
                  rank_out[w] = rank_in[w] - WAY_BITS'(1);
               end
            end
            valid_out[cmd.way] = 1'b0;
            rank_out[cmd.way] = '0;
         end
         ROW_AGE: begin
            for (int w = 0; w < WAYS; w++) begin
               if (valid_in[w]) begin
                  rank_out[w] = rank_in[w] + WAY_BITS'(1);
               end
            end
            if (stat.free_found) begin
               valid_out[stat.free_way] = 1'b1;
               rank_out[stat.free_way] = '0;
            end
         end
         ROW_PROMOTE: begin
            for (int w = 0; w < WAYS; w++) begin
               if (valid_in[w] && rank_in[w] < sel_rank) begin
                  rank_out[w] = rank_in[w] + WAY_BITS'(1);
               end
            end
            rank_out[cmd.way] = '0;
         end
         default: begin
            valid_out = valid_in;
            rank_out = rank_in;
         end
      endcase
   end

endmodule

>>> rtl/core/segmented_lru_cache_top.sv
// Segmented LRU key/value cache, one request word at a time.
// A key scan steps through the ways of the segment with one shared key comparator.
// An insert runs scan, drop, full, age and trim, a hitting get scan and promote, a missing get
// scan alone; done loads the response once the output is free, and ready rises with its valid.
// Reset is synchronous and active high: it clears all valid bits, the entry count and the
// sequencer, and sets the capacity to eight; no clearing pass is needed.
module segmented_lru_cache_top import slru_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   slru_req_if.sink            req_chan,
   slru_rsp_if.source          rsp_chan,
   input  logic                csr_wr_en,
   input  logic [CAP_BITS-1:0] csr_wr_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_DROP = 3'd2;
   localparam logic [2:0] S_FULL = 3'd3;
   localparam logic [2:0] S_AGE = 3'd4;
   localparam logic [2:0] S_TRIM = 3'd5;
   localparam logic [2:0] S_PROMOTE = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   logic [KEY_BITS-1:0]  key_mem [SEGMENTS*WAYS];
   logic [DATA_BITS-1:0] data_mem [SEGMENTS*WAYS];
   rank_row_type         rank_mem [SEGMENTS];
   valid_row_type        valid_ff [SEGMENTS];

   logic [2:0]           state_ff, state_in;
   logic [FILL_BITS-1:0] scan_cnt_ff, scan_cnt_in;
   logic                 found_ff, found_in;
   logic [WAY_BITS-1:0]  found_way_ff, found_way_in;
   valid_row_type        row_valid_ff, row_valid_in;
   rank_row_type         row_rank_ff, row_rank_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic [CAP_BITS-1:0]  cap_ff;
   logic                 kind_ff;
   logic [KEY_BITS-1:0]  key_ff;
   logic [DATA_BITS-1:0] value_ff;
   logic [SEG_BITS-1:0]  seg_ff;
   logic                 cmp_vld_ff;
   logic [WAY_BITS-1:0]  cmp_way_ff;
   logic [KEY_BITS-1:0]  key_rd_ff;
   logic [DATA_BITS-1:0] data_rd_ff;
   rank_row_type         rank_rd_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [DATA_BITS-1:0] rsp_value_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff;

   logic                 accept;
   logic                 cmp_hit;
   logic                 mem_wr;
   logic                 rsp_load;
   logic [CAP_BITS-1:0]  cap_eff;
   logic [SLOT_BITS-1:0] key_raddr;
   logic [SLOT_BITS-1:0] data_raddr;
   logic [SLOT_BITS-1:0] waddr;
   valid_row_type        seg_valid;
   rank_row_type         rank_masked;
   row_cmd_type          cmd;
   row_stat_type         stat;
   valid_row_type        unit_valid;
   rank_row_type         unit_rank;

   slru_row_unit u_row_unit (
      .cmd       (cmd),
      .valid_in  (row_valid_ff),
      .rank_in   (row_rank_ff),
      .valid_out (unit_valid),
      .rank_out  (unit_rank),
      .stat      (stat)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept = req_chan.valid && (state_ff == S_IDLE);

   assign cap_eff = (cap_ff > CAP_BITS'(WAYS)) ? CAP_BITS'(WAYS) : cap_ff;
   assign seg_valid = valid_ff[seg_ff];
   assign cmp_hit = cmp_vld_ff && seg_valid[cmp_way_ff] && (key_rd_ff == key_ff);

   assign key_raddr = {seg_ff, scan_cnt_ff[WAY_BITS-1:0]};
   assign data_raddr = {seg_ff, found_way_ff};
   assign waddr = {seg_ff, stat.free_way};

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         rank_masked[w] = seg_valid[w] ? rank_rd_ff[w] : '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      scan_cnt_in = scan_cnt_ff;
      found_in = found_ff;
      found_way_in = found_way_ff;
      row_valid_in = row_valid_ff;
      row_rank_in = row_rank_ff;
      total_in = total_ff;
      cmd.op = ROW_HOLD;
      cmd.way = found_way_ff;
      mem_wr = 1'b0;
      rsp_load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_SCAN;
               scan_cnt_in = '0;
               found_in = 1'b0;
            end
         end
         S_SCAN: begin
            if (cmp_hit && !found_ff) begin
               found_in = 1'b1;
               found_way_in = cmp_way_ff;
            end
            if (scan_cnt_ff == FILL_BITS'(WAYS)) begin
               row_valid_in = seg_valid;
               row_rank_in = rank_masked;
               if (kind_ff == KIND_INSERT) begin
                  state_in = S_DROP;
               end else if (found_in) begin
                  state_in = S_PROMOTE;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               scan_cnt_in = scan_cnt_ff + FILL_BITS'(1);
            end
         end
         S_DROP: begin
            if (found_ff) begin
               cmd.op = ROW_DROP;
               total_in = total_ff - TOTAL_BITS'(1);
            end
            row_valid_in = unit_valid;
            row_rank_in = unit_rank;
            state_in = S_FULL;
         end
         S_FULL: begin
            if (stat.fill >= FILL_BITS'(WAYS)) begin
               cmd.op = ROW_DROP;
               cmd.way = stat.oldest_way;
               total_in = total_ff - TOTAL_BITS'(1);
            end
            row_valid_in = unit_valid;
            row_rank_in = unit_rank;
            state_in = S_AGE;
         end
         S_AGE: begin
            cmd.op = ROW_AGE;
            if (stat.free_found) begin
               mem_wr = 1'b1;
               total_in = total_ff + TOTAL_BITS'(1);
            end
            row_valid_in = unit_valid;
            row_rank_in = unit_rank;
            state_in = S_TRIM;
         end
         S_TRIM: begin
            if (CAP_BITS'(stat.fill) > cap_eff) begin
               cmd.op = ROW_DROP;
               cmd.way = stat.oldest_way;
               total_in = total_ff - TOTAL_BITS'(1);
            end
            row_valid_in = unit_valid;
            row_rank_in = unit_rank;
            state_in = S_DONE;
         end
         S_PROMOTE: begin
            cmd.op = ROW_PROMOTE;
            row_valid_in = unit_valid;
            row_rank_in = unit_rank;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         scan_cnt_ff <= '0;
         found_ff <= 1'b0;
         total_ff <= '0;
         cap_ff <= CAP_RESET;
         cmp_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < SEGMENTS; s++) begin
            valid_ff[s] <= '0;
         end
      end else begin
         state_ff <= state_in;
         scan_cnt_ff <= scan_cnt_in;
         found_ff <= found_in;
         total_ff <= total_in;
         cmp_vld_ff <= (state_ff == S_SCAN) && (scan_cnt_ff < FILL_BITS'(WAYS));
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            valid_ff[seg_ff] <= row_valid_ff;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      found_way_ff <= found_way_in;
      row_valid_ff <= row_valid_in;
      row_rank_ff <= row_rank_in;
      cmp_way_ff <= scan_cnt_ff[WAY_BITS-1:0];
      if (accept) begin
         kind_ff <= req_chan.kind;
         key_ff <= req_chan.key;
         value_ff <= req_chan.value;
         seg_ff <= req_chan.key[SEG_BITS-1:0];
      end
      if (rsp_load) begin
         rsp_hit_ff <= (kind_ff == KIND_GET) && found_ff;
         rsp_value_ff <= ((kind_ff == KIND_GET) && found_ff) ? data_rd_ff : '0;
         rsp_count_ff <= COUNT_BITS'(total_ff);
      end
   end

   always_ff @(posedge clock) begin
      key_rd_ff <= key_mem[key_raddr];
      data_rd_ff <= data_mem[data_raddr];
      rank_rd_ff <= rank_mem[seg_ff];
      if (mem_wr) begin
         key_mem[waddr] <= key_ff;
         data_mem[waddr] <= value_ff;
      end
      if (rsp_load) begin
         rank_mem[seg_ff] <= row_rank_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.hit = rsp_hit_ff;
   assign rsp_chan.read_value = rsp_value_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

endmodule

>>> rtl/core/slru_checker.sv
// Port-level checker for the segmented LRU cache, bound to the top level.
// Depends on slru_pkg for the widths and the cache size.
module slru_checker import slru_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_hit,
   input logic [DATA_BITS-1:0]  rsp_read_value,
   input logic [COUNT_BITS-1:0] rsp_entry_count
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while the previous word was still in work");

   a_miss_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_read_value == '0)
      else $error("response without a hit carries a non-zero value");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= COUNT_BITS'(SEGMENTS * WAYS))
      else $error("entry count exceeds the cache size");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_count))
      else $error("stalled response word changed or vanished");

endmodule

bind segmented_lru_cache_top slru_checker u_slru_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_hit         (rsp_chan.hit),
   .rsp_read_value  (rsp_chan.read_value),
   .rsp_entry_count (rsp_chan.entry_count)
);
